[hw/rtl/dwis_pkg.sv]
package dwis_pkg;

  // Field widths of the transaction ports.
  localparam int unsigned EntryW  = 4;
  localparam int unsigned WeightW = 16;
  localparam int unsigned RandomW = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned IndexW  = 4;

  // Depth of the queue between the front end and the sampling engine.
  // Kept at a power of two so that the pointers wrap on their own.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Operation carried by one input transaction.
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Classified operation as it travels through the queue.
  typedef struct packed {
    op_e                code;
    logic [EntryW-1:0]  entry;
    logic [WeightW-1:0] weight;
    logic [RandomW-1:0] rnd;
  } op_t;

  // Sampling engine states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_WALK,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/dwis_front.sv]
module dwis_front import dwis_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [EntryW-1:0]  entry_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic [RandomW-1:0] random_value_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output op_t                push_data_o
);

  logic fr_vld_q;
  op_t  fr_op_q;
  op_t  op;
  logic keep;

  // Classify the incoming transaction. A load to an entry beyond the table is dropped here.
  always_comb begin
    op.code   = op_e'(kind_i);
    op.entry  = entry_i;
    op.weight = weight_i;
    op.rnd    = random_value_i;
    keep      = (op.code == OP_SAMPLE) || (32'(entry_i) < MAX_SOURCES);
  end

  // The holding register frees up whenever the queue takes its content.
  assign in_ready_o   = !fr_vld_q || push_ready_i;
  assign push_valid_o = fr_vld_q;
  assign push_data_o  = fr_op_q;

  // Valid flag of the holding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      fr_vld_q <= in_valid_i && keep;
    end
  end

  // Payload of the holding register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      fr_op_q <= op;
    end
  end

endmodule

[hw/rtl/dwis_queue.sv]
module dwis_queue import dwis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_data_o
);

  op_t                  slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/dwis_back.sv]
module dwis_back import dwis_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 16,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] source_count_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  op_t               pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] pick_index_o,
  output logic              no_weight_o
);

  localparam int unsigned IdxW  = $clog2(MAX_SOURCES);
  localparam int unsigned TotW  = WEIGHT_BITS + IdxW;
  localparam int unsigned ProdW = RANDOM_BITS + TotW;

  state_e                 state_q, state_d;
  logic [WEIGHT_BITS-1:0] weight_mem [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] wvld_q;
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   rvld_q;
  logic [IdxW-1:0]        rd_addr;
  logic                   mem_we;

  logic [IdxW-1:0]        entry_q;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [RANDOM_BITS-1:0] rnd_q;
  logic [TotW-1:0]        total_q;
  logic [ProdW-1:0]       prod_q;
  logic [TotW-1:0]        cum_q;
  logic [IdxW-1:0]        idx_q;
  logic [IdxW-1:0]        res_idx_q;
  logic                   res_nw_q;
  logic                   out_vld_q;
  logic [IdxW-1:0]        out_idx_q;
  logic                   out_nw_q;

  logic [IdxW-1:0]        last_idx;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [TotW-1:0]        cum_next;
  logic [TotW-1:0]        prod_hi;
  logic [RANDOM_BITS-1:0] prod_lo;
  logic                   hit;
  logic                   walk_end;
  logic                   out_free;

  // Last entry in use, with the count clamped to the table size.
  always_comb begin
    if (source_count_i == '0) begin
      last_idx = '0;
    end else if (32'(source_count_i) > MAX_SOURCES) begin
      last_idx = IdxW'(MAX_SOURCES - 1);
    end else begin
      last_idx = IdxW'(source_count_i - CountW'(1));
    end
  end

  // An entry never written reads as zero. One step of the cumulative walk and its compare.
  always_comb begin
    rd_weight = rvld_q ? rdata_q : '0;
    cum_next  = cum_q + TotW'(rd_weight);
    prod_hi   = prod_q[ProdW-1:RANDOM_BITS];
    prod_lo   = prod_q[RANDOM_BITS-1:0];
    hit       = (prod_hi < cum_next) || ((prod_hi == cum_next) && (prod_lo == '0));
    walk_end  = hit || (idx_q == last_idx);
    out_free  = !out_vld_q || out_ready_i;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          if (pop_data_i.code == OP_LOAD) begin
            state_d = ST_LOAD;
          end else if (total_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_MUL:  state_d = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Table port control and queue handshake.
  always_comb begin
    pop_ready_o = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_data_i.code == OP_LOAD) begin
          rd_addr = IdxW'(pop_data_i.entry);
        end
      end
      ST_LOAD: mem_we = 1'b1;
      ST_WALK: begin
        rd_addr = (idx_q == last_idx) ? idx_q : idx_q + IdxW'(1);
      end
      default: rd_addr = '0;
    endcase
  end

  // Control state, running total, written flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      wvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LOAD) begin
        total_q         <= total_q - TotW'(rd_weight) + TotW'(weight_q);
        wvld_q[entry_q] <= 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Weight table with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      weight_mem[entry_q] <= weight_q;
    end
    rdata_q <= weight_mem[rd_addr];
    rvld_q  <= wvld_q[rd_addr];
  end

  // Datapath registers of the operation in progress.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        entry_q   <= IdxW'(pop_data_i.entry);
        weight_q  <= WEIGHT_BITS'(pop_data_i.weight);
        rnd_q     <= RANDOM_BITS'(pop_data_i.rnd);
        res_idx_q <= '0;
        res_nw_q  <= (total_q == '0);
        cum_q     <= '0;
        idx_q     <= '0;
      end
      ST_MUL: begin
        prod_q <= ProdW'(rnd_q) * ProdW'(total_q);
      end
      ST_WALK: begin
        cum_q <= cum_next;
        idx_q <= idx_q + IdxW'(1);
        if (walk_end) begin
          res_idx_q <= idx_q;
        end
      end
      default: begin
        cum_q <= cum_q;
      end
    endcase
    if (state_q == ST_DONE && out_free) begin
      out_idx_q <= res_idx_q;
      out_nw_q  <= res_nw_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pick_index_o = IndexW'(out_idx_q);
  assign no_weight_o  = out_nw_q;

  // A zero-total result always reports entry zero.
  a_nw_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_weight_o |-> pick_index_o == '0)
    else $error("no_weight result with nonzero index");

  // The multiply only starts on a nonzero total.
  a_mul_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> total_q != '0)
    else $error("sample multiply started with zero total");

  // The walk never passes the last entry in use.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> idx_q <= last_idx)
    else $error("walk index beyond last entry in use");

  // A finished sample reaches the output register in the next cycle.
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_vld_q)
    else $error("finished sample not presented");

endmodule

[hw/rtl/discrete_weighted_index_sampler.sv]
// A sample passes the front register, the queue, the multiply, one walk step per entry
// walked and the output register; on a zero total it skips the multiply and the walk.
// The engine finishes each sample or load before it pops the next from the queue, and the
// walk is paced by the single weight table read port, walked one entry a cycle.
// Reset: asynchronous active low; the table reads as zero, the total is zero and
// source_count is 1, with no clearing pass.
module discrete_weighted_index_sampler import dwis_pkg::*; #(
  parameter int unsigned MAX_SOURCES = 16,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [EntryW-1:0]  entry_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic [RandomW-1:0] random_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IndexW-1:0]  pick_index_o,
  output logic               no_weight_o
);

  logic [CountW-1:0] source_count_q;
  logic              push_valid;
  logic              push_ready;
  op_t               push_data;
  logic              pop_valid;
  logic              pop_ready;
  op_t               pop_data;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      source_count_q <= cfg_wdata_i;
    end
  end

  // Front end: accepts and classifies transactions.
  dwis_front #(
    .MAX_SOURCES(MAX_SOURCES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .entry_i       (entry_i),
    .weight_i      (weight_i),
    .random_value_i(random_value_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // Queue decoupling the front end from the sampling engine.
  dwis_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Sampling engine: table updates and the cumulative walk.
  dwis_back #(
    .MAX_SOURCES(MAX_SOURCES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .RANDOM_BITS(RANDOM_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .source_count_i(source_count_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pick_index_o  (pick_index_o),
    .no_weight_o   (no_weight_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import dwis_pkg::*;

  // Run length guard and settle time after the last expected result.
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned TableDepth  = 16;

  // One expected sampler result.
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              no_weight;
  } pick_t;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CountW-1:0]  cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               kind_i         = 1'b0;
  logic [EntryW-1:0]  entry_i        = '0;
  logic [WeightW-1:0] weight_i       = '0;
  logic [RandomW-1:0] random_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [IndexW-1:0]  pick_index_o;
  logic               no_weight_o;

  // Shadow copy of the weight table, its total and the entry count.
  logic [WeightW-1:0] weight_shadow [TableDepth];
  logic [19:0]        total_shadow;
  logic [CountW-1:0]  count_shadow;

  pick_t       pending_picks[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;

  discrete_weighted_index_sampler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .entry_i        (entry_i),
    .weight_i       (weight_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pick_index_o   (pick_index_o),
    .no_weight_o    (no_weight_o)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Abort the run if it takes far longer than any correct run could.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls at random with the current stall rate.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Inverse-CDF walk: the first entry in use whose cumulative weight, scaled
  // by 2^32, reaches u times the total. Falls back to the last entry in use.
  function automatic pick_t draw_index(input logic [RandomW-1:0] u);
    logic [63:0] scaled_u;
    logic [19:0] cum;
    int unsigned in_use;
    logic        found;
    pick_t       pick;
    pick.index     = '0;
    pick.no_weight = 1'b1;
    if (total_shadow == 0) return pick;
    scaled_u = {32'b0, u} * {44'b0, total_shadow};
    if (count_shadow == 0) in_use = 1;
    else if (count_shadow > TableDepth) in_use = TableDepth;
    else in_use = int'(count_shadow);
    pick.index     = IndexW'(in_use - 1);
    pick.no_weight = 1'b0;
    cum   = '0;
    found = 1'b0;
    for (int i = 0; i < in_use; i++) begin
      cum = cum + 20'(weight_shadow[i]);
      if (!found && scaled_u <= {12'b0, cum, 32'b0}) begin
        pick.index = IndexW'(i);
        found      = 1'b1;
      end
    end
    return pick;
  endfunction

  // Compare each accepted result with the oldest expected pick.
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result index=%0d no_weight=%0b",
                                  pick_index_o, no_weight_o));
      end else begin
        want = pending_picks.pop_front();
        if (pick_index_o !== want.index)
          report_mismatch($sformatf("pick_index %0d, expected %0d",
                                    pick_index_o, want.index));
        if (no_weight_o !== want.no_weight)
          report_mismatch($sformatf("no_weight %0b, expected %0b",
                                    no_weight_o, want.no_weight));
      end
    end
  end

  // Send one transaction; called and returning at a falling edge. Valid is
  // left high so back-to-back transactions need no extra edge.
  task automatic send_item(input op_e op, input logic [EntryW-1:0] ent,
                           input logic [WeightW-1:0] w, input logic [RandomW-1:0] u);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= op;
    entry_i        <= ent;
    weight_i       <= w;
    random_value_i <= u;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD) begin
      total_shadow       = total_shadow - 20'(weight_shadow[ent]) + 20'(w);
      weight_shadow[ent] = w;
    end else begin
      pending_picks.push_back(draw_index(u));
    end
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected result, then let in-flight loads finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write the entry count register; only called while the block is idle.
  task automatic set_source_count(input logic [CountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    count_shadow = value;
    @(negedge clk_i);
  endtask

  // Samples from an empty table must flag the missing weight.
  task automatic test_empty_table();
    set_source_count(5'd0);
    send_item(OP_SAMPLE, 4'hF, 16'hFFFF, '0);
    send_item(OP_SAMPLE, 4'h0, 16'h0000, '1);
    wait_idle();
  endtask

  // Largest and smallest weights and random values over the full table.
  task automatic test_weight_extremes();
    set_source_count(5'd16);
    send_item(OP_LOAD, 4'd0, 16'hFFFF, '0);
    send_item(OP_LOAD, 4'd15, 16'hFFFF, '0);
    send_item(OP_LOAD, 4'd7, 16'h0001, '1);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'h0000_0000);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'h8000_0000);
    send_item(OP_LOAD, 4'd0, 16'h0000, '0);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'h0000_0001);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'h7FFF_FFFF);
    wait_idle();
  endtask

  // A count of one and counts that are too large, and a walk that runs out
  // because weight sits beyond the entries in use.
  task automatic test_count_limits();
    send_item(OP_LOAD, 4'd0, 16'h0001, '0);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'hFFFF_FFFF);
    wait_idle();
    set_source_count(5'd1);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'hFFFF_FFFF);
    wait_idle();
    set_source_count(5'd31);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'hFFFF_FFFF);
    wait_idle();
    set_source_count(5'd17);
    send_item(OP_SAMPLE, 4'd0, 16'h0, 32'hC000_0000);
    // Clearing every loaded entry brings the total back to zero.
    send_item(OP_LOAD, 4'd0, 16'h0, '0);
    send_item(OP_LOAD, 4'd7, 16'h0, '0);
    send_item(OP_LOAD, 4'd15, 16'h0, '0);
    send_item(OP_SAMPLE, 4'd3, 16'h0, 32'h1234_5678);
    wait_idle();
  endtask

  // Random mix of loads and samples with random content.
  task automatic test_random_traffic(input int unsigned n_items);
    op_e                op;
    logic [WeightW-1:0] w;
    logic [RandomW-1:0] u;
    for (int k = 0; k < n_items; k++) begin
      op = ($urandom_range(99) < 40) ? OP_LOAD : OP_SAMPLE;
      case ($urandom_range(4))
        0:       w = '0;
        1:       w = '1;
        2:       w = WeightW'($urandom_range(255));
        default: w = WeightW'($urandom);
      endcase
      case ($urandom_range(9))
        0:       u = '0;
        1:       u = '1;
        default: u = $urandom;
      endcase
      send_item(op, EntryW'($urandom_range(15)), w, u);
    end
    wait_idle();
  endtask

  initial begin
    logic [CountW-1:0] counts [6];
    counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8};
    error_count     = 0;
    cycle_count     = 0;
    sender_idle_pct = 25;
    sink_stall_pct  = 52;
    foreach (weight_shadow[i]) weight_shadow[i] = '0;
    total_shadow = '0;
    count_shadow = 5'd1;

    // Hold reset, then release it at a falling edge.
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_weight_extremes();
    test_count_limits();

    // Three idling profiles, two count settings in each.
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 25 : (p == 1) ? 52 : 0;
      sink_stall_pct  = (p == 0) ? 52 : (p == 1) ? 25 : 0;
      for (int c = 0; c < 2; c++) begin
        if (p == 2 && c == 1) set_source_count(CountW'($urandom_range(2, 15)));
        else set_source_count(counts[2 * p + c]);
        test_random_traffic(85);
      end
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
